// ===== rtl/core/spectrum_peak_region_finder_core_macros.svh =====
// assertion macros for the spectrum peak region finder core
// sampled on clk_i, disabled while rst_ni is low; empty when SYNTHESIS is set
`ifndef SPECTRUM_PEAK_REGION_FINDER_CORE_MACROS_SVH
`define SPECTRUM_PEAK_REGION_FINDER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SPRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SPRF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SPRF_ASSERT(lbl, prop, msg)
`define SPRF_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/core/sprf_pkg.sv =====
// shared types and constants of the spectrum peak region finder
// used by every module of the core; no dependencies
`default_nettype none

package sprf_pkg;

  localparam int Rounds      = 5;
  localparam int MaxChannels = 16384;
  localparam int RateBits    = 24;
  localparam int Taps        = 6;
  localparam int CountW      = $clog2(MaxChannels + 1);
  localparam int ChanW       = $clog2(MaxChannels);
  localparam int DiffW       = RateBits + 1;
  localparam int SecondW     = RateBits + 3;
  localparam int SmoothW     = 44;
  localparam int ScanStart   = 6 * Rounds + 3;
  localparam int FindOffset  = 3 * Rounds + 3;
  localparam int EndOffset   = 3 * Rounds + 2;

  typedef struct packed {
    logic [RateBits-1:0] ref_rate;
    logic [RateBits-1:0] bg_rate;
    logic                last_channel;
  } sprf_in_t;

  typedef struct packed {
    logic [ChanW-1:0] region_channel;
    logic             region_is_max;
    logic             region_present;
    logic             end_of_spectrum;
  } sprf_out_t;

  // one channel travelling down the cell chain
  typedef struct packed {
    logic                      valid;
    logic                      skip;
    logic                      last;
    logic [ChanW-1:0]          chan;
    logic signed [SmoothW-1:0] smooth;
    logic signed [SmoothW-1:0] pad;
  } sprf_tok_t;

endpackage

`default_nettype wire

// ===== rtl/core/spectrum_peak_region_finder_core.sv =====
// Spectrum peak region finder: Mariscotti style second difference peak search.
// Input channel: one spectrum channel per transaction (ref_rate, bg_rate, last_channel),
// valid/stall handshake. Output channel: one region find or end marker per transaction.
// A channel flows through a front cell (net rate and second difference), a chain of five
// box sum cells and a scan stage; every stage moves one place per clock unless stalled.
// Throughput: one channel per clock unless stalled; if the last channel yields a find
// and the end marker, the chain holds until the find leaves the two-entry register.
// A find reports channel index minus 18; the end marker closes the spectrum and the
// core starts the next spectrum from a clean state.
// Reset clears all history, running sums and scan state; no item is lost or repeated.
// When the receiver stalls a waiting result, the whole chain holds and in_stall_o rises
// in the same cycle, so upstream waits until the waiting result is taken.
// Depends on sprf_pkg, sprf_front, sprf_box_cell, sprf_scan and the macros header.
`default_nettype none
`include "spectrum_peak_region_finder_core_macros.svh"

module spectrum_peak_region_finder_core
  import sprf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  sprf_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output sprf_out_t out_data_o
);

  sprf_tok_t tok [Rounds+1];
  logic      en;

  sprf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .tok_o      (tok[0])
  );

  for (genvar r = 0; r < Rounds; r++) begin : g_cell
    sprf_box_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .tok_i  (tok[r]),
      .tok_o  (tok[r+1])
    );
  end

  sprf_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok[Rounds]),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = ~en;

  `SPRF_ASSERT(a_stall_needs_result, in_stall_o |-> out_valid_o, "input stalled with no result waiting")
  `SPRF_ASSERT(a_empty_is_end, out_valid_o && !out_data_o.region_present |-> out_data_o.end_of_spectrum, "result without region is not an end marker")
  `SPRF_ASSERT(a_max_shape, out_valid_o && out_data_o.region_is_max |-> out_data_o.region_present && !out_data_o.end_of_spectrum, "maximum on an end marker or without region")
  `SPRF_ASSERT(a_chan_floor, out_valid_o && out_data_o.region_present |-> out_data_o.region_channel >= ChanW'(3 * Rounds), "region channel below the smoothing offset")

endmodule

`default_nettype wire

// ===== rtl/core/sprf_front.sv =====
// front cell: background subtraction, second difference and channel counting
// depends on sprf_pkg
`default_nettype none

module sprf_front
  import sprf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      in_valid_i,
  input  sprf_in_t  in_data_i,
  output sprf_tok_t tok_o
);

  logic [CountW-1:0]        count_q, count_d;
  logic signed [DiffW-1:0]  h0_q, h0_d, h1_q, h1_d;
  logic signed [DiffW-1:0]  x;
  logic signed [SecondW-1:0] second;
  logic                     overflow, take;
  logic                     valid_q;
  sprf_tok_t                tok_d, tok_q;

  assign overflow = count_q >= CountW'(MaxChannels);
  assign take     = en_i & in_valid_i;
  assign x        = signed'({1'b0, in_data_i.ref_rate}) - signed'({1'b0, in_data_i.bg_rate});

  always_comb begin
    if (count_q < CountW'(2)) begin
      second = '0;
    end else begin
      second = ({{(SecondW-DiffW){h0_q[DiffW-1]}}, h0_q} <<< 1)
             - {{(SecondW-DiffW){h1_q[DiffW-1]}}, h1_q}
             - {{(SecondW-DiffW){x[DiffW-1]}}, x};
    end
  end

  always_comb begin
    count_d = count_q;
    h0_d    = h0_q;
    h1_d    = h1_q;
    if (take) begin
      if (in_data_i.last_channel) begin
        count_d = '0;
        h0_d    = '0;
        h1_d    = '0;
      end else if (!overflow) begin
        count_d = count_q + CountW'(1);
        h1_d    = h0_q;
        h0_d    = x;
      end
    end
  end

  always_comb begin
    // overflowed channels only travel on when they close the spectrum
    tok_d.valid  = in_valid_i & (~overflow | in_data_i.last_channel);
    tok_d.skip   = overflow;
    tok_d.last   = in_data_i.last_channel;
    tok_d.chan   = count_q[ChanW-1:0];
    tok_d.smooth = {{(SmoothW-SecondW){second[SecondW-1]}}, second};
    tok_d.pad    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      h0_q    <= '0;
      h1_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      h0_q    <= h0_d;
      h1_q    <= h1_d;
      if (en_i) begin
        valid_q <= tok_d.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q <= tok_d;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

`default_nettype wire

// ===== rtl/core/sprf_box_cell.sv =====
// one 7-tap box sum round of the smoothing chain, with running sum
// depends on sprf_pkg
`default_nettype none

module sprf_box_cell
  import sprf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  sprf_tok_t tok_i,
  output sprf_tok_t tok_o
);

  logic signed [SmoothW-1:0] win_q [Taps];
  logic signed [SmoothW-1:0] sum_q;
  logic signed [SmoothW-1:0] sum, sum_next, pad;
  logic                      valid_q;
  logic                      update;
  sprf_tok_t                 tok_d, tok_q;

  assign sum      = sum_q + tok_i.smooth;
  assign sum_next = sum - win_q[Taps-1];
  // running sum of the following rounds with a zero input, kept for the end padding
  assign pad      = tok_i.pad + sum_next;
  assign update   = en_i & tok_i.valid;

  always_comb begin
    tok_d        = tok_i;
    tok_d.smooth = sum;
    tok_d.pad    = pad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      valid_q <= 1'b0;
      for (int i = 0; i < Taps; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (en_i) begin
        valid_q <= tok_i.valid;
      end
      if (update) begin
        if (tok_i.last) begin
          sum_q <= '0;
          for (int i = 0; i < Taps; i++) begin
            win_q[i] <= '0;
          end
        end else if (!tok_i.skip) begin
          sum_q    <= sum_next;
          win_q[0] <= tok_i.smooth;
          for (int i = 1; i < Taps; i++) begin
            win_q[i] <= win_q[i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q <= tok_d;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

`default_nettype wire

// ===== rtl/core/sprf_scan.sv =====
// extremum scan of the smoothed stream and the two-entry result register
// depends on sprf_pkg; drives the chain enable
`default_nettype none

module sprf_scan
  import sprf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sprf_tok_t tok_i,
  output logic      en_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output sprf_out_t out_data_o
);

  logic signed [SmoothW-1:0] prev_q;
  logic                      seek_max_q;
  logic                      live, scanned, find_min, find_max, find, is_end;
  logic                      seek_new, end_found;
  sprf_out_t                 res_find, res_end, r0;
  logic                      r0_valid, r1_valid;
  logic                      out_valid_q, second_valid_q;
  sprf_out_t                 out_q, second_q;

  assign live     = tok_i.valid & ~tok_i.skip;
  assign scanned  = live & (tok_i.chan >= ChanW'(ScanStart));
  assign find_min = scanned & ~seek_max_q & (prev_q < tok_i.smooth);
  assign find_max = scanned & seek_max_q & (prev_q > tok_i.smooth);
  assign find     = find_min | find_max;
  assign seek_new = find_min | (seek_max_q & ~find_max);
  assign is_end   = tok_i.valid & tok_i.last;
  // trailing minimum against the zero padded next value
  assign end_found = scanned & tok_i.last & ~seek_new & (tok_i.smooth > tok_i.pad);

  always_comb begin
    res_find.region_channel  = tok_i.chan - ChanW'(FindOffset);
    res_find.region_is_max   = find_max;
    res_find.region_present  = 1'b1;
    res_find.end_of_spectrum = 1'b0;
    res_end.region_channel   = end_found ? tok_i.chan - ChanW'(EndOffset) : '0;
    res_end.region_is_max    = 1'b0;
    res_end.region_present   = end_found;
    res_end.end_of_spectrum  = 1'b1;
    r0       = find ? res_find : res_end;
    r0_valid = find | is_end;
    r1_valid = find & is_end;
  end

  assign en_o = ~out_valid_q | (~out_stall_i & ~second_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q         <= '0;
      seek_max_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      second_valid_q <= 1'b0;
    end else begin
      if (en_o) begin
        out_valid_q    <= r0_valid;
        second_valid_q <= r1_valid;
        if (is_end) begin
          prev_q     <= '0;
          seek_max_q <= 1'b0;
        end else if (live) begin
          prev_q     <= tok_i.smooth;
          seek_max_q <= seek_new;
        end
      end else if (!out_stall_i) begin
        // first transaction taken, the end marker moves up
        out_valid_q    <= second_valid_q;
        second_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      out_q    <= r0;
      second_q <= res_end;
    end else if (!out_stall_i) begin
      out_q <= second_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== tb/tb_spectrum_peak_region_finder_core.sv =====
// self-checking testbench for spectrum_peak_region_finder_core: random spectra, random idling
// on both channels, in-bench peak search predictor compared against every output transaction
// depends on sprf_pkg and the core rtl
`default_nettype none

module tb_spectrum_peak_region_finder_core;
  import sprf_pkg::*;

  localparam int IdleLimit   = 4000;
  localparam int RandomItems = 1150;
  localparam int HoldCycles  = 300;

  typedef enum int {SHAPE_FULL, SHAPE_FAINT, SHAPE_DEFICIT, SHAPE_PEAKS} spec_shape_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  sprf_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  sprf_out_t out_data_o;

  spectrum_peak_region_finder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // peak search predictor state
  logic signed [DiffW-1:0]   net_hist [2];
  logic signed [SmoothW-1:0] box_win [Rounds][Taps];
  logic signed [SmoothW-1:0] box_sum [Rounds];
  logic signed [SmoothW-1:0] last_smooth;
  bit                        seek_max;
  int unsigned               chan_cnt;

  sprf_in_t  chan_pending [$];
  sprf_out_t region_q [$];

  int  err_count = 0;
  int  results_taken = 0;
  int  idle_cycles = 0;
  bit  in_took = 0;
  bit  out_took = 0;
  bit  out_seen = 0;
  int  tx_gap = 0;
  int  rx_wait = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  bit  tx_burst = 0;
  bit  rx_burst = 0;

  function automatic int draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic sprf_out_t mk_region(int unsigned chan, bit is_max, bit present, bit eos);
    sprf_out_t r;
    r.region_channel  = chan[ChanW-1:0];
    r.region_is_max   = is_max;
    r.region_present  = present;
    r.end_of_spectrum = eos;
    return r;
  endfunction

  task automatic clear_finder();
    net_hist[0] = '0;
    net_hist[1] = '0;
    for (int k = 0; k < Rounds; k++) begin
      box_sum[k] = '0;
      for (int j = 0; j < Taps; j++) box_win[k][j] = '0;
    end
    last_smooth = '0;
    seek_max    = 1'b0;
    chan_cnt    = 0;
  endtask

  task automatic predict_channel(input sprf_in_t it);
    logic signed [DiffW-1:0]   net;
    logic signed [SmoothW-1:0] stage, acc, pad;
    bit                        scanned;
    scanned = 1'b0;
    // beyond the channel limit only the end mark matters
    if (chan_cnt >= MaxChannels) begin
      if (it.last_channel) begin
        region_q.push_back(mk_region(0, 1'b0, 1'b0, 1'b1));
        clear_finder();
      end
      return;
    end
    net = $signed({1'b0, it.ref_rate}) - $signed({1'b0, it.bg_rate});
    if (chan_cnt >= 2) stage = 2 * net_hist[0] - net_hist[1] - net;
    else stage = '0;
    net_hist[1] = net_hist[0];
    net_hist[0] = net;
    for (int k = 0; k < Rounds; k++) begin
      acc = box_sum[k] + stage;
      box_sum[k] = acc - box_win[k][Taps-1];
      for (int j = Taps - 1; j > 0; j--) box_win[k][j] = box_win[k][j-1];
      box_win[k][0] = stage;
      stage = acc;
    end
    if (chan_cnt >= ScanStart) begin
      scanned = 1'b1;
      if (!seek_max && last_smooth < stage) begin
        region_q.push_back(mk_region(chan_cnt - FindOffset, 1'b0, 1'b1, 1'b0));
        seek_max = 1'b1;
      end else if (seek_max && last_smooth > stage) begin
        region_q.push_back(mk_region(chan_cnt - FindOffset, 1'b1, 1'b1, 1'b0));
        seek_max = 1'b0;
      end
    end
    last_smooth = stage;
    chan_cnt++;
    if (it.last_channel) begin
      // trailing minimum against the zero padded next smoothed value
      pad = '0;
      for (int k = 0; k < Rounds; k++) pad = box_sum[k] + pad;
      if (scanned && !seek_max && stage > pad)
        region_q.push_back(mk_region(chan_cnt - 1 - EndOffset, 1'b0, 1'b1, 1'b1));
      else
        region_q.push_back(mk_region(0, 1'b0, 1'b0, 1'b1));
      clear_finder();
    end
  endtask

  task automatic push_chan(logic [RateBits-1:0] ref_v, logic [RateBits-1:0] bg_v, bit last);
    sprf_in_t it;
    it.ref_rate     = ref_v;
    it.bg_rate      = bg_v;
    it.last_channel = last;
    chan_pending.push_back(it);
  endtask

  task automatic add_spectrum(int len, spec_shape_e shape);
    int unsigned base, spacing, wid, hgt, offs;
    logic [RateBits-1:0] ref_v, bg_v;
    base    = $urandom_range(0, 1 << 16);
    spacing = $urandom_range(12, 40);
    wid     = $urandom_range(2, 10);
    hgt     = $urandom_range(1 << 10, 1 << 22);
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_FULL: begin
          ref_v = RateBits'($urandom_range(0, (1 << RateBits) - 1));
          bg_v  = RateBits'($urandom_range(0, (1 << RateBits) - 1));
        end
        SHAPE_FAINT: begin
          ref_v = RateBits'($urandom_range(0, 255));
          bg_v  = RateBits'($urandom_range(0, 255));
        end
        SHAPE_DEFICIT: begin
          ref_v = RateBits'($urandom_range(0, 1 << 20));
          bg_v  = RateBits'($urandom_range(1 << 23, (1 << RateBits) - 1));
        end
        default: begin
          // periodic triangular peaks on a flat baseline
          offs = i % spacing;
          if (offs > spacing / 2) offs = spacing - offs;
          ref_v = RateBits'(base + $urandom_range(0, 255)
                            + ((offs < wid) ? hgt / wid * (wid - offs) : 0));
          bg_v  = RateBits'(base / 2 + $urandom_range(0, 127));
        end
      endcase
      push_chan(ref_v, bg_v, i == len - 1);
    end
  endtask

  // driver: new transaction at the falling edge once the previous one is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (chan_pending.size() > 0) begin
        in_data_i  <= chan_pending.pop_front();
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        tx_gap = draw_wait(tx_burst);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off to back the core up
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (hold_left > 0) hold_left--;
      else if (results_taken >= 40 && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (out_took) begin
        if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
        rx_wait = draw_wait(rx_burst);
      end else if (out_seen && rx_wait > 0) begin
        rx_wait--;
      end
      out_stall_i <= (hold_left > 0) || (rx_wait > 0);
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    sprf_out_t want;
    if (rst_ni) begin
      in_took  <= in_valid_i && !in_stall_o;
      out_took <= out_valid_o && !out_stall_i;
      out_seen <= out_valid_o;
      if (in_valid_i && !in_stall_o) predict_channel(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        results_taken++;
        if (region_q.size() == 0) begin
          $error("unexpected output transaction: channel %0d max %0d present %0d end %0d",
                 out_data_o.region_channel, out_data_o.region_is_max,
                 out_data_o.region_present, out_data_o.end_of_spectrum);
          err_count++;
        end else begin
          want = region_q.pop_front();
          if (out_data_o.region_channel !== want.region_channel) begin
            $error("region_channel expected %0d actual %0d",
                   want.region_channel, out_data_o.region_channel);
            err_count++;
          end
          if (out_data_o.region_is_max !== want.region_is_max) begin
            $error("region_is_max expected %0d actual %0d",
                   want.region_is_max, out_data_o.region_is_max);
            err_count++;
          end
          if (out_data_o.region_present !== want.region_present) begin
            $error("region_present expected %0d actual %0d",
                   want.region_present, out_data_o.region_present);
            err_count++;
          end
          if (out_data_o.end_of_spectrum !== want.end_of_spectrum) begin
            $error("end_of_spectrum expected %0d actual %0d",
                   want.end_of_spectrum, out_data_o.end_of_spectrum);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int          random_items;
    int          len;
    int          pick;
    spec_shape_e shape;
    random_items  = 0;
    clear_finder();

    // single channel, two channel and short extreme spectra
    push_chan('1, '0, 1'b1);
    push_chan('0, '1, 1'b0);
    push_chan('1, '1, 1'b1);
    for (int i = 0; i < 12; i++)
      push_chan((i % 2) ? '1 : '0, (i % 3 == 0) ? '1 : '0, i == 11);
    push_chan('0, '0, 1'b1);

    while (random_items < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) len = $urandom_range(1, ScanStart);
      else if (pick < 20) len = $urandom_range(ScanStart, ScanStart + 2);
      else len = $urandom_range(ScanStart + 3, 120);
      pick = $urandom_range(0, 9);
      if (pick < 5) shape = SHAPE_PEAKS;
      else if (pick < 7) shape = SHAPE_FULL;
      else if (pick < 9) shape = SHAPE_FAINT;
      else shape = SHAPE_DEFICIT;
      add_spectrum(len, shape);
      random_items += len;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (chan_pending.size() > 0 || in_valid_i) @(posedge clk_i);
    while (region_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sprf_pkg.sv
rtl/core/sprf_front.sv
rtl/core/sprf_box_cell.sv
rtl/core/sprf_scan.sv
rtl/core/spectrum_peak_region_finder_core.sv
tb/tb_spectrum_peak_region_finder_core.sv
